### rtl/tvd_pkg.sv
// Package for the Telex decoder: job type, queue status, key tables.
// No dependencies; used by every module of the decoder by scoped names.

package tvd_pkg;

	localparam int CHAR_W      = 16;
	localparam int PEND_DEPTH  = 2;   // characters held between items
	localparam int JOB_SLOTS   = 3;   // most results one item can cause
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef logic [CHAR_W-1:0] char_t;

	// One unit of work for the back end: up to three result characters.
	typedef struct packed {
		char_t [JOB_SLOTS-1:0] ch;    // ch[0] goes out first
		logic  [1:0]           num;   // number of valid slots, 1..3
		logic                  last;  // final slot closes the string
	} tvd_job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} tvd_qstat_t;

	typedef struct packed {
		logic  hit;
		char_t code;
	} tvd_hit_t;

	// Three-character keys.
	function automatic tvd_hit_t key3(char_t a, char_t b, char_t c);
		tvd_hit_t r;
		r.hit  = 1'b1;
		r.code = '0;
		case ({a, b, c})
			48'h0061_0061_0066: r.code = 16'h1EA7;
			48'h0061_0061_006A: r.code = 16'h1EAD;
			48'h0061_0061_0072: r.code = 16'h1EA9;
			48'h0061_0061_0073: r.code = 16'h1EA5;
			48'h0061_0061_0078: r.code = 16'h1EAB;
			48'h0061_0077_0066: r.code = 16'h1EB1;
			48'h0061_0077_006A: r.code = 16'h1EB7;
			48'h0061_0077_0072: r.code = 16'h1EB3;
			48'h0061_0077_0073: r.code = 16'h1EAF;
			48'h0061_0077_0078: r.code = 16'h1EB5;
			48'h0065_0065_0066: r.code = 16'h1EC1;
			48'h0065_0065_006A: r.code = 16'h1EC7;
			48'h0065_0065_0072: r.code = 16'h1EC3;
			48'h0065_0065_0073: r.code = 16'h1EBF;
			48'h0065_0065_0078: r.code = 16'h1EC5;
			48'h006F_006F_0066: r.code = 16'h1ED3;
			48'h006F_006F_006A: r.code = 16'h1ED9;
			48'h006F_006F_0072: r.code = 16'h1ED5;
			48'h006F_006F_0073: r.code = 16'h1ED1;
			48'h006F_006F_0078: r.code = 16'h1ED7;
			48'h006F_0077_0066: r.code = 16'h1EDD;
			48'h006F_0077_006A: r.code = 16'h1EE3;
			48'h006F_0077_0072: r.code = 16'h1EDF;
			48'h006F_0077_0073: r.code = 16'h1EDB;
			48'h006F_0077_0078: r.code = 16'h1EE1;
			48'h0075_0077_0066: r.code = 16'h1EEB;
			48'h0075_0077_006A: r.code = 16'h1EF1;
			48'h0075_0077_0072: r.code = 16'h1EED;
			48'h0075_0077_0073: r.code = 16'h1EE9;
			48'h0075_0077_0078: r.code = 16'h1EEF;
			default:            r.hit  = 1'b0;
		endcase
		return r;
	endfunction

	// Two-character keys.
	function automatic tvd_hit_t key2(char_t a, char_t b);
		tvd_hit_t r;
		r.hit  = 1'b1;
		r.code = '0;
		case ({a, b})
			32'h0061_0061: r.code = 16'h00E2;
			32'h0061_0066: r.code = 16'h00E0;
			32'h0061_006A: r.code = 16'h1EA1;
			32'h0061_0072: r.code = 16'h1EA3;
			32'h0061_0073: r.code = 16'h00E1;
			32'h0061_0077: r.code = 16'h0103;
			32'h0061_0078: r.code = 16'h00E3;
			32'h0064_0064: r.code = 16'h0111;
			32'h0065_0065: r.code = 16'h00EA;
			32'h0065_0066: r.code = 16'h00E8;
			32'h0065_006A: r.code = 16'h1EB9;
			32'h0065_0072: r.code = 16'h1EBB;
			32'h0065_0073: r.code = 16'h00E9;
			32'h0065_0078: r.code = 16'h1EBD;
			32'h0069_0066: r.code = 16'h00EC;
			32'h0069_006A: r.code = 16'h1ECB;
			32'h0069_0072: r.code = 16'h1EC9;
			32'h0069_0073: r.code = 16'h00ED;
			32'h0069_0078: r.code = 16'h0129;
			32'h006F_0066: r.code = 16'h00F2;
			32'h006F_006A: r.code = 16'h1ECD;
			32'h006F_006F: r.code = 16'h00F4;
			32'h006F_0072: r.code = 16'h1ECF;
			32'h006F_0073: r.code = 16'h00F3;
			32'h006F_0077: r.code = 16'h01A1;
			32'h006F_0078: r.code = 16'h00F5;
			32'h0075_0066: r.code = 16'h00F9;
			32'h0075_006A: r.code = 16'h1EE5;
			32'h0075_0072: r.code = 16'h1EE7;
			32'h0075_0073: r.code = 16'h00FA;
			32'h0075_0077: r.code = 16'h01B0;
			32'h0075_0078: r.code = 16'h0169;
			32'h0079_0066: r.code = 16'h1EF3;
			32'h0079_006A: r.code = 16'h1EF5;
			32'h0079_0072: r.code = 16'h1EF7;
			32'h0079_0073: r.code = 16'h00FD;
			32'h0079_0078: r.code = 16'h1EF9;
			default:       r.hit  = 1'b0;
		endcase
		return r;
	endfunction

endpackage

### rtl/telex_to_vietnamese_decoder_core.sv
// Top level of the Telex to Vietnamese stream decoder.
// Depends on tvd_pkg, tvd_front, tvd_queue and tvd_back.
//
//   channel  | direction | tdata          | tlast     | meaning
//   s_axis   | in        | [15:0] in_char | in_last   | Telex characters
//   m_axis   | out       | [15:0] out_char| out_last  | decoded characters
//
// One input character is taken per cycle while the job queue has room; a
// character that completes a window of three, or one marked last, queues a
// job of one to three output characters.
// The back end moves one output character per cycle while the output is ready,
// so a flush of three characters takes three output transfers; the four-entry
// queue absorbs that while the input keeps flowing.
// An input that queues a job passes the queue slot and then the output register.
// Reset clears the pending count, the queue pointers and the output valid;
// no clearing pass is needed.

module telex_to_vietnamese_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] in_char
	input  logic        s_axis_tlast,   // in_last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] out_char
	output logic        m_axis_tlast    // out_last
);

	tvd_pkg::tvd_qstat_t qstat;
	tvd_pkg::tvd_job_t   job, head;
	logic                push, pop;

	// Classify each transfer against the key tables and keep the window.
	tvd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_char  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.qstat    (qstat),
		.push     (push),
		.job      (job)
	);

	// Hold finished jobs so either side can stall on its own.
	tvd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (job),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	// Drain each job one character per output transfer.
	tvd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.qstat     (qstat),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_char  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

### rtl/tvd_front.sv
// Front end: holds the pending window, matches keys, forms jobs.
// Depends on tvd_pkg.

module tvd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  tvd_pkg::char_t     in_char,
	input  logic               in_last,
	input  tvd_pkg::tvd_qstat_t qstat,
	output logic               push,
	output tvd_pkg::tvd_job_t  job
);

	tvd_pkg::char_t pend_q [tvd_pkg::PEND_DEPTH];
	logic [1:0]     cnt_q;

	tvd_pkg::char_t   w0, w1, w2;
	tvd_pkg::tvd_hit_t k3, k20, k21;
	logic             accept;
	logic [1:0]       cnt_d;
	tvd_pkg::char_t   p0_d, p1_d;
	logic             p0_we, p1_we;

	assign in_ready = !qstat.full;
	assign accept   = in_valid && in_ready;

	// Line up the window: pending characters first, new character after.
	always_comb begin
		w0 = in_char;
		w1 = in_char;
		w2 = in_char;
		case (cnt_q)
			2'd0: w0 = in_char;
			2'd1: begin
				w0 = pend_q[0];
				w1 = in_char;
			end
			default: begin
				w0 = pend_q[0];
				w1 = pend_q[1];
				w2 = in_char;
			end
		endcase
	end

	assign k3  = tvd_pkg::key3(w0, w1, w2);
	assign k20 = tvd_pkg::key2(w0, w1);
	assign k21 = tvd_pkg::key2(w1, w2);

	always_comb begin
		job      = '0;
		job.ch   = {w2, w1, w0};
		job.last = in_last;
		job.num  = 2'd1;
		push     = 1'b0;
		cnt_d    = cnt_q;
		p0_d     = w1;
		p1_d     = w2;
		p0_we    = 1'b0;
		p1_we    = 1'b0;
		if (in_last) begin
			push  = 1'b1;
			cnt_d = 2'd0;
			case (cnt_q)
				2'd0: job.num = 2'd1;
				2'd1: begin
					if (k20.hit) begin
						job.ch[0] = k20.code;
						job.num   = 2'd1;
					end else begin
						job.num   = 2'd2;
					end
				end
				default: begin
					if (k3.hit) begin
						job.ch[0] = k3.code;
						job.num   = 2'd1;
					end else if (k20.hit) begin
						job.ch[0] = k20.code;
						job.ch[1] = w2;
						job.num   = 2'd2;
					end else if (k21.hit) begin
						job.ch[1] = k21.code;
						job.num   = 2'd2;
					end else begin
						job.num   = 2'd3;
					end
				end
			endcase
		end else begin
			case (cnt_q)
				2'd0: begin
					p0_d  = in_char;
					p0_we = 1'b1;
					cnt_d = 2'd1;
				end
				2'd1: begin
					p1_d  = in_char;
					p1_we = 1'b1;
					cnt_d = 2'd2;
				end
				default: begin
					push = 1'b1;
					if (k3.hit) begin
						job.ch[0] = k3.code;
						cnt_d     = 2'd0;
					end else if (k20.hit) begin
						job.ch[0] = k20.code;
						p0_d      = w2;
						p0_we     = 1'b1;
						cnt_d     = 2'd1;
					end else begin
						p0_we     = 1'b1;
						p1_we     = 1'b1;
						cnt_d     = 2'd2;
					end
				end
			endcase
		end
		push = push && accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (accept) begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && p0_we) begin
			pend_q[0] <= p0_d;
		end
		if (accept && p1_we) begin
			pend_q[1] <= p1_d;
		end
	end

endmodule

### rtl/tvd_queue.sv
// Job queue between front and back end; small register FIFO.
// Depends on tvd_pkg.

module tvd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  tvd_pkg::tvd_job_t   push_job,
	input  logic                pop,
	output tvd_pkg::tvd_job_t   head,
	output tvd_pkg::tvd_qstat_t qstat
);

	tvd_pkg::tvd_job_t               slot_q [tvd_pkg::QUEUE_DEPTH];
	logic [tvd_pkg::QPTR_W-1:0]      wr_ptr_q, rd_ptr_q;
	logic [tvd_pkg::QCNT_W-1:0]      count_q;
	logic                            do_push, do_pop;

	assign qstat.full  = (count_q == tvd_pkg::QCNT_W'(tvd_pkg::QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign head        = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

### rtl/tvd_back.sv
// Back end: walks the slots of the head job into the output register.
// Depends on tvd_pkg.

module tvd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  tvd_pkg::tvd_job_t   head,
	input  tvd_pkg::tvd_qstat_t qstat,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output tvd_pkg::char_t      out_char,
	output logic                out_last
);

	logic           valid_q;
	tvd_pkg::char_t char_q;
	logic           last_q;
	logic [1:0]     idx_q;
	logic           load, final_slot;

	assign out_valid  = valid_q;
	assign out_char   = char_q;
	assign out_last   = last_q;
	assign load       = !qstat.empty && (!valid_q || out_ready);
	assign final_slot = (idx_q == head.num - 2'd1);
	assign pop        = load && final_slot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= final_slot ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= head.ch[idx_q];
			last_q <= head.last && final_slot;
		end
	end

endmodule
